### sv/ucd_pkg.sv
// shared constants and types for the undirected cycle detector
// used by ucd_lane, ucd_merge and undirected_cycle_detect_core
package ucd_pkg;

  localparam int ROW_W            = 16;
  localparam int IDX_W            = $clog2(ROW_W);
  localparam int CFG_W            = 5;
  localparam int CMP_W            = 8;
  localparam int MAX_VERTICES_DEF = 16;

  localparam logic [CFG_W-1:0] VCOUNT_RST = CFG_W'(16);

  typedef struct packed {
    logic hit;
    logic seen;
    logic is_parent;
  } lane_flag_t;

  typedef struct packed {
    logic             any;
    logic [IDX_W-1:0] idx;
    logic             seen;
    logic             is_parent;
  } pick_t;

endpackage

### sv/ucd_lane.sv
// one neighbor lane: checks a single column of the current adjacency row
// depends on ucd_pkg
module ucd_lane import ucd_pkg::*; #(
  parameter int LANE = 0,
  parameter int CW   = 5
) (
  input  logic          edge_bit,
  input  logic          seen_in,
  input  logic [CW-1:0] scan_from,
  input  logic [CW-1:0] count,
  input  logic [CW-1:0] parent,
  output lane_flag_t    flag
);

  localparam logic [CMP_W-1:0] ME = CMP_W'(LANE);

  always_comb begin
    flag.hit       = edge_bit && (ME >= CMP_W'(scan_from)) && (ME < CMP_W'(count));
    flag.seen      = seen_in;
    flag.is_parent = (ME == CMP_W'(parent));
  end

endmodule

### sv/ucd_merge.sv
// merge stage: picks the lowest lane with a live edge
// depends on ucd_pkg
module ucd_merge import ucd_pkg::*; (
  input  lane_flag_t flags [ROW_W],
  output pick_t      pick
);

  always_comb begin
    pick = '0;
    for (int i = ROW_W - 1; i >= 0; i--) begin
      if (flags[i].hit) begin
        pick.any       = 1'b1;
        pick.idx       = IDX_W'(i);
        pick.seen      = flags[i].seen;
        pick.is_parent = flags[i].is_parent;
      end
    end
  end

endmodule

### sv/undirected_cycle_detect_core.sv
// undirected cycle detector: row store, depth-first walk sequencer, neighbor lanes
// depends on ucd_pkg, ucd_lane, ucd_merge
//
// usage:
//   rows of the adjacency matrix come in on the input channel (row_bits, last_row),
//   one per transfer, in row order; a row is taken only while the block is idle.
//   the transfer with last_row set starts a depth-first search over vertex_count
//   vertices; in_stall stays high until the result has been placed in the output
//   register, then has_cycle is offered on the output channel (out_valid/out_stall).
//   search steps: each root is tested in S_ROOT; each vertex entered costs a row fetch,
//   a final scan, a pop, a frame reload and a parent row refetch, and each edge followed
//   costs a scan; sixteen neighbor lanes test a whole row at once, so non-edges cost
//   nothing. the walk stops at the first cycle. the stack and row store are
//   single-port memories, which set the per-vertex cost.
//   a pending result is held while out_stall is high; new rows are still taken, but a
//   later search result waits until the output register is free.
//   vertex_count is written through cfg_write_en/cfg_write_data; the user must write it while idle (not enforced).
//   rst (synchronous) returns the block to idle with vertex_count 16 and no result
//   pending; stored rows keep their contents.
module undirected_cycle_detect_core import ucd_pkg::*; #(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [ROW_W-1:0] row_bits,
  input  logic             last_row,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             has_cycle,
  input  logic             cfg_write_en,
  input  logic [CFG_W-1:0] cfg_write_data
);

  localparam int VW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);
  localparam int FW = VW + 2 * CW;
  localparam logic [CW-1:0] NONE  = CW'(MAX_VERTICES);
  localparam logic [CW-1:0] ONE_C = CW'(1);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_ROOT  = 7'b0000010,
    S_FETCH = 7'b0000100,
    S_SCAN  = 7'b0001000,
    S_POP   = 7'b0010000,
    S_LOAD  = 7'b0100000,
    S_PUT   = 7'b1000000
  } state_t;

  state_t                  state;
  logic [CFG_W-1:0]        vertex_count;
  logic [CW-1:0]           row_counter;
  logic [CW-1:0]           root;
  logic [CW-1:0]           depth;
  logic [VW-1:0]           cur_vertex;
  logic [CW-1:0]           cur_parent;
  logic [CW-1:0]           cur_next;
  logic [MAX_VERTICES-1:0] visited;
  logic [ROW_W-1:0]        adj_row;
  logic [FW-1:0]           stack_rd;
  logic                    found;

  logic [ROW_W-1:0] adj_mem   [MAX_VERTICES];
  logic [FW-1:0]    stack_mem [MAX_VERTICES];

  logic             in_xfer;
  logic             out_free;
  logic [CMP_W-1:0] n_wide;
  logic [CW-1:0]    n;
  logic             root_in;
  logic             root_seen;
  logic [CW-1:0]    dm1;
  logic [CW-1:0]    dm2;
  logic             push_ok;
  logic [VW-1:0]    sel_v;
  logic [CW-1:0]    sel_next;
  logic             do_push;
  logic [ROW_W-1:0] lane_seen;
  lane_flag_t       flags [ROW_W];
  pick_t            pick;

  assign in_stall = (state != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  assign n_wide = (CMP_W'(vertex_count) > CMP_W'(MAX_VERTICES)) ?
                  CMP_W'(MAX_VERTICES) : CMP_W'(vertex_count);
  assign n      = CW'(n_wide);

  assign root_in   = (root < n);
  assign root_seen = visited[root[VW-1:0]];
  assign dm1       = depth - ONE_C;
  assign dm2       = depth - CW'(2);
  assign push_ok   = (depth < NONE);
  assign sel_v     = VW'(pick.idx);
  assign sel_next  = CW'({1'b0, pick.idx} + (IDX_W + 1)'(1));
  assign do_push   = (state == S_SCAN) && pick.any && !pick.seen && push_ok;

  // neighbor lanes
  for (genvar j = 0; j < ROW_W; j++) begin : g_lane
    if (j < MAX_VERTICES) begin : g_vis
      assign lane_seen[j] = visited[j];
    end else begin : g_novis
      assign lane_seen[j] = 1'b0;
    end

    ucd_lane #(
      .LANE (j),
      .CW   (CW)
    ) u_lane (
      .edge_bit  (adj_row[j]),
      .seen_in   (lane_seen[j]),
      .scan_from (cur_next),
      .count     (n),
      .parent    (cur_parent),
      .flag      (flags[j])
    );
  end

  ucd_merge u_merge (
    .flags (flags),
    .pick  (pick)
  );

  // row store
  always_ff @(posedge clk) begin
    if (in_xfer && (row_counter < NONE)) begin
      adj_mem[row_counter[VW-1:0]] <= row_bits;
    end
    if (state == S_FETCH) begin
      adj_row <= adj_mem[cur_vertex];
    end
  end

  // walk stack
  always_ff @(posedge clk) begin
    if (do_push) begin
      stack_mem[dm1[VW-1:0]] <= {cur_vertex, cur_parent, sel_next};
    end
    if ((state == S_POP) && (depth != ONE_C)) begin
      stack_rd <= stack_mem[dm2[VW-1:0]];
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      vertex_count <= VCOUNT_RST;
      row_counter  <= '0;
      root         <= '0;
      depth        <= '0;
      cur_vertex   <= '0;
      cur_parent   <= '0;
      cur_next     <= '0;
      visited      <= '0;
      found        <= 1'b0;
      out_valid    <= 1'b0;
      has_cycle    <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        vertex_count <= cfg_write_data;
      end
      if (out_valid && !out_stall && (state != S_PUT)) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_xfer) begin
            if (last_row) begin
              row_counter <= '0;
              visited     <= '0;
              root        <= '0;
              depth       <= '0;
              state       <= S_ROOT;
            end else if (row_counter < NONE) begin
              row_counter <= row_counter + ONE_C;
            end
          end
        end
        S_ROOT: begin
          if (!root_in) begin
            found <= 1'b0;
            state <= S_PUT;
          end else if (root_seen) begin
            root <= root + ONE_C;
          end else begin
            visited[root[VW-1:0]] <= 1'b1;
            cur_vertex            <= root[VW-1:0];
            cur_parent            <= NONE;
            cur_next              <= '0;
            depth                 <= ONE_C;
            state                 <= S_FETCH;
          end
        end
        S_FETCH: begin
          state <= S_SCAN;
        end
        S_SCAN: begin
          if (!pick.any) begin
            state <= S_POP;
          end else if (!pick.seen) begin
            visited[sel_v] <= 1'b1;
            if (push_ok) begin
              depth      <= depth + ONE_C;
              cur_vertex <= sel_v;
              cur_parent <= CW'(cur_vertex);
              cur_next   <= '0;
              state      <= S_FETCH;
            end else begin
              cur_next <= sel_next;
            end
          end else begin
            cur_next <= sel_next;
            if (!pick.is_parent) begin
              found <= 1'b1;
              state <= S_PUT;
            end
          end
        end
        S_POP: begin
          if (depth == ONE_C) begin
            depth <= '0;
            root  <= root + ONE_C;
            state <= S_ROOT;
          end else begin
            depth <= dm1;
            state <= S_LOAD;
          end
        end
        S_LOAD: begin
          {cur_vertex, cur_parent, cur_next} <= stack_rd;
          state                              <= S_FETCH;
        end
        S_PUT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            has_cycle <= found;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### sim/tb_top.sv
// self-checking testbench for undirected_cycle_detect_core: adjacency rows are queued,
// sent by a clocked driver, and each has_cycle is checked against a local depth-first walk
// depends on ucd_pkg and the undirected_cycle_detect_core rtl
module tb_top;
  import ucd_pkg::*;

  localparam int MAX_V      = MAX_VERTICES_DEF;
  localparam int ROW_TARGET = 1050;
  localparam int CALM_ROWS  = 900;
  localparam int DRAIN_CYC  = 64;
  localparam int HOLD_CYC   = 400;
  localparam int LIMIT_CYC  = 2000000;

  typedef struct {
    logic [ROW_W-1:0] bits;
    logic             last;
  } row_item_t;

  logic             clk            = 1'b0;
  logic             rst            = 1'b1;
  logic             in_valid       = 1'b0;
  logic             in_stall;
  logic [ROW_W-1:0] row_bits       = '0;
  logic             last_row       = 1'b0;
  logic             out_valid;
  logic             out_stall      = 1'b0;
  logic             has_cycle;
  logic             cfg_write_en   = 1'b0;
  logic [CFG_W-1:0] cfg_write_data = '0;

  row_item_t        pending_rows [$];
  logic             expected_cycle_flags [$];
  logic [ROW_W-1:0] adj_copy [MAX_V];
  logic [CFG_W-1:0] vcount_copy = VCOUNT_RST;
  int               row_ptr = 0;

  row_item_t        next_row;
  logic             want_cycle;
  bit               calm = 1'b0;
  int               gap_left = 0;
  int               stall_left = 0;
  int               hold_left = 0;
  bit               hold_used = 1'b0;
  int               rows_queued = 0;
  int               rows_taken = 0;
  int               matrices_taken = 0;
  int               results_seen = 0;
  int               cycles_reported = 0;
  int               settings_written = 0;
  int               mismatch_count = 0;
  int               cycle_count = 0;

  undirected_cycle_detect_core #(
    .MAX_VERTICES(MAX_V)
  ) i_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .row_bits      (row_bits),
    .last_row      (last_row),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .has_cycle     (has_cycle),
    .cfg_write_en  (cfg_write_en),
    .cfg_write_data(cfg_write_data)
  );

  always #4 clk = ~clk;

  function automatic logic search_for_cycle(int unsigned n);
    logic        seen [MAX_V];
    int unsigned frame_vtx [MAX_V];
    int unsigned frame_par [MAX_V];
    int unsigned frame_next [MAX_V];
    int unsigned depth;
    int unsigned top;
    int unsigned j;
    for (int i = 0; i < MAX_V; i++) seen[i] = 1'b0;
    for (int unsigned root = 0; root < n; root++) begin
      if (!seen[root]) begin
        seen[root] = 1'b1;
        frame_vtx[0] = root;
        frame_par[0] = MAX_V;
        frame_next[0] = 0;
        depth = 1;
        while (depth > 0) begin
          top = depth - 1;
          j = frame_next[top];
          if (j >= n) begin
            depth--;
          end else begin
            frame_next[top] = j + 1;
            if (adj_copy[frame_vtx[top]][j]) begin
              if (!seen[j]) begin
                seen[j] = 1'b1;
                if (depth < MAX_V) begin
                  frame_vtx[depth] = j;
                  frame_par[depth] = frame_vtx[top];
                  frame_next[depth] = 0;
                  depth++;
                end
              end else if (j != frame_par[top]) begin
                return 1'b1;
              end
            end
          end
        end
      end
    end
    return 1'b0;
  endfunction

  function automatic void store_row_and_predict(logic [ROW_W-1:0] bits, logic last);
    int unsigned n;
    if (row_ptr < MAX_V) begin
      adj_copy[row_ptr] = bits;
      row_ptr++;
    end
    rows_taken++;
    if (last) begin
      n = (vcount_copy > MAX_V) ? MAX_V : vcount_copy;
      expected_cycle_flags.push_back(search_for_cycle(n));
      row_ptr = 0;
      matrices_taken++;
    end
  endfunction

  function automatic bit block_idle();
    return pending_rows.size() == 0 && !in_valid && expected_cycle_flags.size() == 0;
  endfunction

  task automatic report_mismatch(string what, logic want, logic got);
    $display("mismatch %s: expected %b got %b at cycle %0d", what, want, got, cycle_count);
    mismatch_count++;
  endtask

  task automatic push_row(logic [ROW_W-1:0] bits, logic last);
    row_item_t item;
    item.bits = bits;
    item.last = last;
    pending_rows.push_back(item);
    rows_queued++;
  endtask

  task automatic write_vertex_count(logic [CFG_W-1:0] value);
    @(negedge clk);
    while (!block_idle()) @(negedge clk);
    repeat (8) @(negedge clk);
    @(posedge clk);
    cfg_write_en <= 1'b1;
    cfg_write_data <= value;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    vcount_copy = value;
    settings_written++;
    @(negedge clk);
  endtask

  task automatic queue_matrix(int unsigned n);
    logic [ROW_W-1:0] rows [MAX_V];
    logic [ROW_W-1:0] low_mask;
    int unsigned      kind;
    int unsigned      count;
    int unsigned      u;
    int unsigned      w;
    kind = $urandom_range(0, 9);
    low_mask = (n >= ROW_W) ? '1 : ((ROW_W'(1) << n) - ROW_W'(1));
    for (int i = 0; i < MAX_V; i++) rows[i] = ROW_W'($urandom) & ~low_mask;
    count = (n == 0) ? $urandom_range(1, 3) : n;
    if (n > 0) begin
      if (kind <= 5) begin
        // forest, optionally closed by one extra edge or a self-loop
        for (int unsigned v = 1; v < n; v++) begin
          if ($urandom_range(0, 3) != 0) begin
            u = $urandom_range(0, v - 1);
            rows[v][u] = 1'b1;
            rows[u][v] = 1'b1;
          end
        end
        if ($urandom_range(0, 1) != 0) begin
          u = $urandom_range(0, n - 1);
          w = $urandom_range(0, n - 1);
          rows[u][w] = 1'b1;
          rows[w][u] = 1'b1;
        end
      end else if (kind == 6) begin
        for (int unsigned a = 0; a < n; a++) begin
          for (int unsigned b = a; b < n; b++) begin
            if ($urandom_range(0, 2) == 0) begin
              rows[a][b] = 1'b1;
              rows[b][a] = 1'b1;
            end
          end
        end
      end else begin
        for (int i = 0; i < MAX_V; i++) rows[i] = ROW_W'($urandom);
        if (kind == 8) begin
          count = $urandom_range(1, n);
        end else if (kind == 9) begin
          count = ($urandom_range(0, 1) != 0) ? $urandom_range(MAX_V + 1, MAX_V + 3)
                                              : n + $urandom_range(1, 3);
        end
      end
    end
    for (int unsigned i = 0; i < count; i++) begin
      push_row((i < MAX_V) ? rows[i] : ROW_W'($urandom), i == count - 1);
    end
  endtask

  // sender
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        store_row_and_predict(row_bits, last_row);
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (!calm && $urandom_range(0, 6) == 0) begin
          gap_left = $urandom_range(0, 3);
          in_valid <= 1'b0;
        end else if (pending_rows.size() > 0) begin
          next_row = pending_rows.pop_front();
          in_valid <= 1'b1;
          row_bits <= next_row.bits;
          last_row <= next_row.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver and result check
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_cycle_flags.size() == 0) begin
          report_mismatch("unexpected result transfer", 1'bx, has_cycle);
        end else begin
          want_cycle = expected_cycle_flags.pop_front();
          if (has_cycle !== want_cycle) report_mismatch("has_cycle", want_cycle, has_cycle);
        end
        results_seen++;
        if (has_cycle === 1'b1) cycles_reported++;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!hold_used && results_seen == 15) begin
        // long hold so the output register stays full and the input backs up
        hold_used = 1'b1;
        hold_left = HOLD_CYC - 1;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 3);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYC) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    logic [CFG_W-1:0] vc;
    int unsigned      n;
    int               phase_end;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset count of 16: a full path writes every row, no cycle
    for (int i = 0; i < MAX_V; i++) begin
      push_row(((i > 0) ? (ROW_W'(1) << (i - 1)) : '0) |
               ((i < MAX_V - 1) ? (ROW_W'(1) << (i + 1)) : '0), i == MAX_V - 1);
    end
    // single vertex: self-loop, then all other bits set
    write_vertex_count(CFG_W'(1));
    push_row(16'h0001, 1'b1);
    push_row(16'hFFFE, 1'b1);
    // zero vertices
    write_vertex_count(CFG_W'(0));
    push_row(16'hFFFF, 1'b1);
    // count above maximum, short matrix over stale rows
    write_vertex_count('1);
    push_row(16'hFFFF, 1'b1);
    // one-way edge only
    write_vertex_count(CFG_W'(3));
    push_row(16'h0002, 1'b0);
    push_row(16'h0000, 1'b0);
    push_row(16'h0000, 1'b1);

    while (rows_queued < ROW_TARGET) begin
      if (rows_queued > CALM_ROWS) calm = 1'b1;
      case ($urandom_range(0, 9))
        0: vc = CFG_W'(0);
        1: vc = CFG_W'($urandom_range(MAX_V + 1, (1 << CFG_W) - 1));
        2: vc = ($urandom_range(0, 1) != 0) ? CFG_W'(MAX_V) : CFG_W'(1);
        default: vc = CFG_W'($urandom_range(1, MAX_V));
      endcase
      write_vertex_count(vc);
      n = (vc > MAX_V) ? MAX_V : vc;
      phase_end = rows_queued + $urandom_range(60, 160);
      while (rows_queued < phase_end && rows_queued < ROW_TARGET) queue_matrix(n);
    end

    @(negedge clk);
    while (!block_idle()) @(negedge clk);
    repeat (DRAIN_CYC) @(negedge clk);
    $display("%0d rows in %0d matrices over %0d vertex_count settings, %0d results (%0d cycles)",
             rows_taken, matrices_taken, settings_written, results_seen, cycles_reported);
    $display("included zero and saturated counts, stale and extra rows, and a long output hold");
    if (mismatch_count == 0 && expected_cycle_flags.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatch_count,
               expected_cycle_flags.size());
      $display("FAILURE");
    end
    $finish;
  end

endmodule
